>>> design/vu_meter_ballistics_macros.svh
// Assertion macros for the VU meter block.
// Used by the top level only; no other dependencies.
`ifndef VU_METER_BALLISTICS_MACROS_SVH
`define VU_METER_BALLISTICS_MACROS_SVH
`ifndef SYNTH
`define VU_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define VU_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`else
`define VU_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define VU_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

>>> design/vumb_pkg.sv
// Shared types and constants of the VU meter block.
// No dependencies.
`default_nettype none
package vumb_pkg;
  localparam logic [1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [1:0] MODE_FRAME   = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  localparam logic [2:0] REG_WINDOW  = 3'd0;
  localparam logic [2:0] REG_ATTACK  = 3'd1;
  localparam logic [2:0] REG_DECAY   = 3'd2;
  localparam logic [2:0] REG_RELEASE = 3'd3;
  localparam logic [2:0] REG_HOLD    = 3'd4;
  localparam logic [2:0] REG_FALL    = 3'd5;
  localparam logic [2:0] REG_FADE    = 3'd6;
  localparam logic [2:0] REG_CLIP    = 3'd7;

  localparam logic [15:0] NEEDLE_REST = 16'd196;
  localparam logic [15:0] CLIP_REST   = 16'd655;
  localparam logic [15:0] DB_GAIN     = 16'd4384;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SREAD, ST_SUPD, ST_LOGL, ST_LOGR, ST_CH, ST_OUT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       ring_rd;
    logic       smp_upd;
    logic       log_ls;
    logic       ch_upd;
    logic       ch_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
  } stat_t;

  typedef struct packed {
    logic [12:0] window_len;
    logic [15:0] attack_gain;
    logic [15:0] decay_gain;
    logic [15:0] release_gain;
    logic [7:0]  hold_ticks;
    logic [15:0] fall_step;
    logic [15:0] lamp_fade;
    logic [15:0] clip_threshold;
  } cfg_t;
endpackage
`default_nettype wire

>>> design/vumb_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`default_nettype none
module vumb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/vumb_ctrl.sv
// Controller state machine of the VU meter.
// Depends on vumb_pkg.
`default_nettype none
module vumb_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_fire,
  input  wire              out_busy,
  input  vumb_pkg::stat_t  stat,
  output logic             in_ready,
  output logic             out_load,
  output vumb_pkg::cmd_t   cmd
);
  import vumb_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_SREAD;
      end
      ST_SREAD: begin
        unique case (stat.mode)
          MODE_SAMPLE:  state_nxt = ST_SUPD;
          MODE_FRAME:   state_nxt = ST_LOGL;
          MODE_RELEASE: state_nxt = ST_CH;
          default:      state_nxt = ST_IDLE;
        endcase
      end
      ST_SUPD: state_nxt = ST_IDLE;
      ST_LOGL: state_nxt = ST_LOGR;
      ST_LOGR: state_nxt = ST_CH;
      ST_CH:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
      end
      ST_SREAD: cmd.ring_rd = 1'b1;
      ST_SUPD:  cmd.smp_upd = 1'b1;
      ST_LOGL:  cmd.log_ls = 1'b1;
      ST_LOGR: begin
        cmd.log_ls = 1'b1;
        cmd.ch_sel = 1'b1;
      end
      ST_CH:   cmd.ch_upd = 1'b1;
      ST_OUT:  out_load = !out_busy;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> design/vumb_dp.sv
// Datapath of the VU meter: window sums, level conversion, ballistics.
// Depends on vumb_pkg and vumb_ram.
`default_nettype none
module vumb_dp #(
  parameter int MAX_WINDOW  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  vumb_pkg::cmd_t                 cmd,
  input  vumb_pkg::cfg_t                 cfg,
  input  wire                            restart,
  input  wire  [1:0]                     in_mode,
  input  wire  signed [SAMPLE_BITS-1:0]  in_left,
  input  wire  signed [SAMPLE_BITS-1:0]  in_right,
  output vumb_pkg::stat_t                stat,
  output logic [15:0]                    needle [2],
  output logic [15:0]                    peak [2],
  output logic [15:0]                    clip [2],
  output logic                           moving
);
  import vumb_pkg::*;
  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SQW = 2 * SAMPLE_BITS;
  localparam int SW = SQW + CW;
  localparam int LW = 7 + 16;

  logic [1:0]             mode_r;
  logic [SAMPLE_BITS-1:0] smp_r [2];
  logic [AW-1:0]          wp_r;
  logic [CW-1:0]          fill_r;
  logic [SW-1:0]          sum_r [2];
  logic [7:0]             hold_r [2];
  logic [15:0]            norm_r [2];
  logic [2*SAMPLE_BITS-1:0] old_q;
  logic                   drop_r;

  assign stat.mode = mode_r;

  logic [CW-1:0] w_eff;
  always_comb begin
    priority if (cfg.window_len == '0) w_eff = CW'(1);
    else if (32'(cfg.window_len) > MAX_WINDOW) w_eff = CW'(MAX_WINDOW);
    else w_eff = CW'(cfg.window_len);
  end

  vumb_ram #(.WIDTH(2*SAMPLE_BITS), .DEPTH(MAX_WINDOW)) u_ring (
    .clk(clk), .we(cmd.smp_upd), .waddr(wp_r),
    .wdata({smp_r[1], smp_r[0]}), .re(cmd.ring_rd),
    .raddr(wp_r - AW'(w_eff)), .rdata(old_q)
  );

  function automatic logic [SQW-1:0] sq(input logic [SAMPLE_BITS-1:0] r);
    logic [SAMPLE_BITS:0] m;
    m = r[SAMPLE_BITS-1] ? ((SAMPLE_BITS+1)'(1) << SAMPLE_BITS) - {1'b0, r} : {1'b0, r};
    return SQW'(m) * SQW'(m);
  endfunction

  function automatic logic [LW-1:0] lg2(input logic [SW-1:0] x);
    logic [6:0] e;
    logic [SW+15:0] sh;
    e = '0;
    for (int i = 0; i < SW; i++) if (x[i]) e = 7'(i);
    sh = {x, 16'd0} >> e;
    return {e, sh[15:0]};
  endfunction

  logic [LW-1:0] top, ls_c;
  logic [LW:0]   d;
  logic [LW+16:0] red;
  logic [15:0]   lvl;
  assign ls_c = lg2(sum_r[cmd.ch_sel]);
  always_comb begin
    top = lg2(SW'(fill_r)) + (LW'(2 * (SAMPLE_BITS - 1)) << 16);
    d   = {1'b0, top} - {1'b0, ls_c};
    red = (LW+17)'(d) * (LW+17)'(DB_GAIN);
    priority if (fill_r == '0 || sum_r[cmd.ch_sel] == '0) lvl = 16'd0;
    else if (ls_c >= top) lvl = 16'hFFFF;
    else if (red[LW+16:16] >= (LW+1)'(65536)) lvl = 16'd0;
    else if (red[LW+16:16] == '0) lvl = 16'hFFFF;
    else lvl = 16'(17'h10000 - 17'(red[LW+16:16]));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      smp_r[0] <= in_left;
      smp_r[1] <= in_right;
    end
    if (cmd.ring_rd) drop_r <= fill_r >= w_eff;
    if (cmd.log_ls) norm_r[cmd.ch_sel] <= lvl;
  end

  logic [15:0] n_nxt [2], p_nxt [2], c_nxt [2];
  logic [7:0]  h_nxt [2];
  logic        mv [2];
  always_comb begin
    logic [31:0] prod;
    logic [15:0] n;
    for (int c = 0; c < 2; c++) begin
      n = needle[c];
      mv[c] = 1'b0;
      h_nxt[c] = hold_r[c];
      p_nxt[c] = peak[c];
      if (mode_r == MODE_FRAME) begin
        if (norm_r[c] > n) begin
          prod = 32'(norm_r[c] - n) * 32'(cfg.attack_gain);
          n = n + prod[31:16];
        end else begin
          prod = 32'(n - norm_r[c]) * 32'(cfg.decay_gain);
          n = n - prod[31:16];
        end
        if (n >= peak[c]) begin
          p_nxt[c] = n;
          h_nxt[c] = cfg.hold_ticks;
        end else if (hold_r[c] != '0) h_nxt[c] = hold_r[c] - 8'd1;
        else p_nxt[c] = peak[c] > cfg.fall_step ? peak[c] - cfg.fall_step : 16'd0;
        prod = 32'(clip[c]) * 32'(cfg.lamp_fade);
        c_nxt[c] = norm_r[c] >= cfg.clip_threshold ? 16'hFFFF : prod[31:16];
      end else begin
        prod = 32'(n) * 32'(cfg.release_gain);
        n = n - prod[31:16];
        if (n > NEEDLE_REST) mv[c] = 1'b1;
        else n = 16'd0;
        if (hold_r[c] != '0) h_nxt[c] = hold_r[c] - 8'd1;
        else p_nxt[c] = peak[c] > cfg.fall_step ? peak[c] - cfg.fall_step : 16'd0;
        if (p_nxt[c] > NEEDLE_REST) mv[c] = 1'b1;
        prod = 32'(clip[c]) * 32'(cfg.lamp_fade);
        c_nxt[c] = prod[31:16];
        if (c_nxt[c] > CLIP_REST) mv[c] = 1'b1;
        else c_nxt[c] = 16'd0;
      end
      n_nxt[c] = n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      fill_r <= '0;
      sum_r[0] <= '0;
      sum_r[1] <= '0;
      for (int c = 0; c < 2; c++) begin
        needle[c] <= '0;
        peak[c] <= '0;
        clip[c] <= '0;
        hold_r[c] <= '0;
      end
      moving <= 1'b0;
    end else begin
      if (restart) begin
        fill_r <= '0;
        sum_r[0] <= '0;
        sum_r[1] <= '0;
      end else if (cmd.smp_upd) begin
        for (int c = 0; c < 2; c++)
          sum_r[c] <= sum_r[c] + SW'(sq(smp_r[c]))
                      - (drop_r ? SW'(sq(old_q[c*SAMPLE_BITS +: SAMPLE_BITS])) : SW'(0));
        if (!drop_r) fill_r <= fill_r + CW'(1);
      end
      if (cmd.smp_upd) wp_r <= wp_r + AW'(1);
      if (cmd.ch_upd) begin
        for (int c = 0; c < 2; c++) begin
          needle[c] <= n_nxt[c];
          peak[c]   <= p_nxt[c];
          clip[c]   <= c_nxt[c];
          hold_r[c] <= h_nxt[c];
        end
        moving <= (mode_r == MODE_RELEASE) && (mv[0] || mv[1]);
      end
    end
  end
endmodule
`default_nettype wire

>>> design/vu_meter_ballistics.sv
// Stereo VU meter, one item at a time (vumb_ctrl): sample item ST_SREAD, ST_SUPD; frame
// tick ST_SREAD, ST_LOGL, ST_LOGR, ST_CH, ST_OUT; release tick ST_SREAD, ST_CH, ST_OUT.
// A result sits in an output register; the next item is taken while it waits.
// rst_n synchronous: levels, sums, pointer and registers to their defaults.
// Ring contents are not cleared; the fill count guards reads.
`default_nettype none
module vu_meter_ballistics #(
  parameter int MAX_WINDOW  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // left_sample, right_sample from bit 0
  input  wire  [2*SAMPLE_BITS-1:0] in_tdata,
  // mode
  input  wire  [1:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // left_needle, right_needle, left_peak_mark, right_peak_mark,
  // left_clip_level, right_clip_level from bit 0
  output logic [95:0] out_tdata,
  // still_moving
  output logic        out_tuser,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [4:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import vumb_pkg::*;
  `include "vu_meter_ballistics_macros.svh"

  cfg_t  cfg_r;
  cmd_t  cmd;
  stat_t stat;
  logic  wr, restart, out_load, ctrl_ready, busy_in;
  logic [15:0] needle [2], peak [2], clip [2];
  logic  moving;
  logic [2:0] ridx;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign ridx = cfg_paddr[4:2];
  assign restart = wr && ridx == REG_WINDOW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{13'd2205, 16'd22938, 16'd9830, 16'd3932, 8'd48, 16'd655,
                 16'd61604, 16'd49807};
    end else if (wr) begin
      unique case (ridx)
        REG_WINDOW:  cfg_r.window_len     <= cfg_pwdata[12:0];
        REG_ATTACK:  cfg_r.attack_gain    <= cfg_pwdata[15:0];
        REG_DECAY:   cfg_r.decay_gain     <= cfg_pwdata[15:0];
        REG_RELEASE: cfg_r.release_gain   <= cfg_pwdata[15:0];
        REG_HOLD:    cfg_r.hold_ticks     <= cfg_pwdata[7:0];
        REG_FALL:    cfg_r.fall_step      <= cfg_pwdata[15:0];
        REG_FADE:    cfg_r.lamp_fade      <= cfg_pwdata[15:0];
        REG_CLIP:    cfg_r.clip_threshold <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_WINDOW:  cfg_prdata = {19'd0, cfg_r.window_len};
      REG_ATTACK:  cfg_prdata = {16'd0, cfg_r.attack_gain};
      REG_DECAY:   cfg_prdata = {16'd0, cfg_r.decay_gain};
      REG_RELEASE: cfg_prdata = {16'd0, cfg_r.release_gain};
      REG_HOLD:    cfg_prdata = {24'd0, cfg_r.hold_ticks};
      REG_FALL:    cfg_prdata = {16'd0, cfg_r.fall_step};
      REG_FADE:    cfg_prdata = {16'd0, cfg_r.lamp_fade};
      REG_CLIP:    cfg_prdata = {16'd0, cfg_r.clip_threshold};
      default:     cfg_prdata = '0;
    endcase
  end

  assign busy_in = out_tvalid && !out_tready;
  assign in_tready = ctrl_ready;

  vumb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready),
    .out_busy(busy_in), .stat(stat), .in_ready(ctrl_ready),
    .out_load(out_load), .cmd(cmd)
  );

  vumb_dp #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .cfg(cfg_r), .restart(restart),
    .in_mode(in_tuser), .in_left(in_tdata[SAMPLE_BITS-1:0]),
    .in_right(in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]), .stat(stat),
    .needle(needle), .peak(peak), .clip(clip), .moving(moving)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (out_load) out_tvalid <= 1'b1;
    else if (out_tready) out_tvalid <= 1'b0;
    if (out_load) begin
      out_tdata <= {clip[1], clip[0], peak[1], peak[0], needle[1], needle[0]};
      out_tuser <= moving;
    end
  end

  `VU_ASSERT_IMP(a_load_free, clk, rst_n, out_load, !out_tvalid || out_tready)
  `VU_ASSERT_NXT(a_load_valid, clk, rst_n, out_load, out_tvalid)
  `VU_ASSERT_IMP(a_no_move_frame, clk, rst_n, cmd.ch_upd && stat.mode == MODE_FRAME, !cmd.load)
endmodule
`default_nettype wire
